>>> sv/paired_error_statistics_core_assert.svh
// Assertion macros for the paired error statistics core.
`ifndef PAIRED_ERROR_STATISTICS_CORE_ASSERT_SVH
`define PAIRED_ERROR_STATISTICS_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising aclk edge outside reset.
`define PES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising aclk edge outside reset.
`define PES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pes_pkg.sv
// Shared widths, select codes and controller/datapath interface types.
package pes_pkg;

    localparam int IN_W           = 24;
    localparam int CNT_W          = 13;
    localparam int SUM_W          = 37;
    localparam int SQ_W           = 60;
    localparam int CROSS_W        = 61;
    localparam int DSQ_W          = 62;
    localparam int ABS_W          = 38;
    localparam int PEAK_W         = 25;
    localparam int PROD_IN_W      = 2 * IN_W;
    localparam int DSQ_IN_W       = 2 * (IN_W + 1);
    localparam int RMS_W          = 25;
    localparam int MAE_W          = 25;
    localparam int CORR_W         = 17;
    localparam int MAX_ERR_W      = 24;
    localparam int MAG_W          = 72;
    localparam int PROD_W         = 2 * MAG_W;
    localparam int SPROD_W        = PROD_W + 1;
    localparam int CORR_FRAC      = 32;
    localparam int DIV_W          = PROD_W + CORR_FRAC;
    localparam int DVSR_W         = PROD_W;
    localparam int RAD_W          = 64;
    localparam int ROOT_W         = RAD_W / 2;
    localparam int MIN_CORR_PAIRS = 3;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int MAX_PAIRS_DEF   = 4096;

    typedef enum logic [2:0] {
        MUL_N_XY = 3'd0,
        MUL_X_Y  = 3'd1,
        MUL_N_XX = 3'd2,
        MUL_X_X  = 3'd3,
        MUL_N_YY = 3'd4,
        MUL_Y_Y  = 3'd5,
        MUL_A_A  = 3'd6,
        MUL_B_C  = 3'd7
    } mul_sel_t;

    typedef enum logic [1:0] {
        DIV_MAE  = 2'd0,
        DIV_RMS  = 2'd1,
        DIV_CORR = 2'd2
    } div_sel_t;

    typedef enum logic {
        SQ_RMS  = 1'b0,
        SQ_CORR = 1'b1
    } sqrt_sel_t;

    typedef enum logic [2:0] {
        CAP_NONE = 3'd0,
        CAP_T1   = 3'd1,
        CAP_A    = 3'd2,
        CAP_B    = 3'd3,
        CAP_C    = 3'd4
    } cap_t;

    typedef struct packed {
        logic      accept_en;
        logic      start_mul;
        mul_sel_t  mul_sel;
        cap_t      cap;
        logic      start_div;
        div_sel_t  div_sel;
        logic      start_sqrt;
        sqrt_sel_t sqrt_sel;
        logic      load_out;
    } cmd_t;

    typedef struct packed {
        logic eos_taken;
        logic pipe_busy;
        logic out_busy;
        logic mul_done;
        logic div_done;
        logic sqrt_done;
    } stat_t;

endpackage

>>> sv/pes_mul.sv
// Bit-serial signed multiplier, one multiplier bit per cycle.
module pes_mul (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [pes_pkg::SPROD_W-1:0] op_a,
    input  logic signed [pes_pkg::SPROD_W-1:0] op_b,
    output logic                               done,
    output logic signed [pes_pkg::SPROD_W-1:0] res
);
    import pes_pkg::*;

    localparam int MCNT_W = $clog2(MAG_W + 1);

    logic [MAG_W-1:0]          mc_reg;
    logic [MAG_W-1:0]          mp_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic                      neg_reg;
    logic [MCNT_W-1:0]         cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic signed [SPROD_W-1:0] res_reg;
    logic [MAG_W:0]            part_sum;
    logic [SPROD_W-1:0]        prod_ext;

    function automatic logic [MAG_W-1:0] mag(input logic signed [SPROD_W-1:0] v);
        logic [SPROD_W-1:0] m;
        m = v[SPROD_W-1] ? -v : v;
        return m[MAG_W-1:0];
    endfunction

    assign part_sum = {1'b0, prod_reg[PROD_W-1:MAG_W]} + {1'b0, (mp_reg[0] ? mc_reg : '0)};
    assign prod_ext = {1'b0, prod_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= MCNT_W'(MAG_W);
            end else if (busy_reg) begin
                if (cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - 1'b1;
                end else begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mc_reg   <= mag(op_a);
            mp_reg   <= mag(op_b);
            prod_reg <= '0;
            neg_reg  <= op_a[SPROD_W-1] ^ op_b[SPROD_W-1];
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                prod_reg <= {part_sum, prod_reg[MAG_W-1:1]};
                mp_reg   <= mp_reg >> 1;
            end else begin
                res_reg <= neg_reg ? -$signed(prod_ext) : $signed(prod_ext);
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

>>> sv/pes_div.sv
// Restoring divider, one quotient bit per cycle.
module pes_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pes_pkg::DIV_W-1:0]   dividend,
    input  logic [pes_pkg::DVSR_W-1:0]  divisor,
    output logic                        done,
    output logic [pes_pkg::DIV_W-1:0]   quotient
);
    import pes_pkg::*;

    localparam int DCNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  quo_reg;
    logic [DVSR_W-1:0] rem_reg;
    logic [DVSR_W-1:0] dvsr_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVSR_W:0]   trial;
    logic [DVSR_W:0]   diff;
    logic              ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvsr_reg};
    assign ge    = trial >= {1'b0, dvsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> sv/pes_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module pes_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pes_pkg::RAD_W-1:0]   radicand,
    output logic                        done,
    output logic [pes_pkg::ROOT_W-1:0]  root
);
    import pes_pkg::*;

    localparam int SCNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              ge;

    assign rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial  = {root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SCNT_W'(ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
            rad_reg  <= rad_reg << 2;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> sv/pes_datapath.sv
// Datapath: accumulation pipeline, shared arithmetic units and result register.
module pes_datapath #(
    parameter int SAMPLE_BITS = pes_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_PAIRS   = pes_pkg::MAX_PAIRS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pes_pkg::cmd_t                       cmd,
    output pes_pkg::stat_t                      status,
    input  logic                                s_valid,
    input  logic signed [pes_pkg::IN_W-1:0]     s_reference_value,
    input  logic signed [pes_pkg::IN_W-1:0]     s_measured_value,
    input  logic                                s_end_of_set,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pes_pkg::RMS_W-1:0]           m_rms_error,
    output logic [pes_pkg::MAE_W-1:0]           m_mean_abs_error,
    output logic signed [pes_pkg::CORR_W-1:0]   m_correlation,
    output logic [pes_pkg::MAX_ERR_W-1:0]       m_max_abs_error,
    output logic [pes_pkg::CNT_W-1:0]           m_pair_count,
    output logic                                m_capacity_overflow
);
    import pes_pkg::*;

    localparam int SHIFT = IN_W - SAMPLE_BITS;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAIRS);
    localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(MIN_CORR_PAIRS);

    // Input sign extension and absolute difference.
    logic signed [IN_W-1:0] x_sh, y_sh, x_in, y_in;
    logic [IN_W:0]          d_u, ad_in;
    logic                   accept, take;

    assign x_sh   = s_reference_value <<< SHIFT;
    assign y_sh   = s_measured_value <<< SHIFT;
    assign x_in   = x_sh >>> SHIFT;
    assign y_in   = y_sh >>> SHIFT;
    assign d_u    = {x_in[IN_W-1], x_in} - {y_in[IN_W-1], y_in};
    assign ad_in  = d_u[IN_W] ? (~d_u + 1'b1) : d_u;
    assign accept = s_valid & cmd.accept_en;

    logic [CNT_W-1:0] count_reg;
    logic             dropped_reg;
    assign take = accept & (count_reg < MAX_CNT);

    logic                       v1_reg, v2_reg;
    logic signed [IN_W-1:0]     x1_reg, y1_reg, x2_reg, y2_reg;
    logic [IN_W:0]              ad1_reg, ad2_reg;
    logic signed [PROD_IN_W-1:0] xx2_reg, yy2_reg, xy2_reg;
    logic [DSQ_IN_W-1:0]        dsq2_reg;

    logic signed [SUM_W-1:0]   sum_ref_reg, sum_meas_reg;
    logic signed [SQ_W-1:0]    sum_ref_sq_reg, sum_meas_sq_reg;
    logic signed [CROSS_W-1:0] sum_cross_reg;
    logic [DSQ_W-1:0]          sum_diff_sq_reg;
    logic [ABS_W-1:0]          sum_abs_diff_reg;
    logic [PEAK_W-1:0]         peak_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= take;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        x1_reg   <= x_in;
        y1_reg   <= y_in;
        ad1_reg  <= ad_in;
        x2_reg   <= x1_reg;
        y2_reg   <= y1_reg;
        ad2_reg  <= ad1_reg;
        xx2_reg  <= x1_reg * x1_reg;
        yy2_reg  <= y1_reg * y1_reg;
        xy2_reg  <= x1_reg * y1_reg;
        dsq2_reg <= ad1_reg * ad1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load_out) begin
            count_reg        <= '0;
            dropped_reg      <= 1'b0;
            sum_ref_reg      <= '0;
            sum_meas_reg     <= '0;
            sum_ref_sq_reg   <= '0;
            sum_meas_sq_reg  <= '0;
            sum_cross_reg    <= '0;
            sum_diff_sq_reg  <= '0;
            sum_abs_diff_reg <= '0;
            peak_reg         <= '0;
        end else begin
            if (take) begin
                count_reg <= count_reg + 1'b1;
            end else if (accept) begin
                dropped_reg <= 1'b1;
            end
            if (v2_reg) begin
                sum_ref_reg     <= sum_ref_reg + {{(SUM_W-IN_W){x2_reg[IN_W-1]}}, x2_reg};
                sum_meas_reg    <= sum_meas_reg + {{(SUM_W-IN_W){y2_reg[IN_W-1]}}, y2_reg};
                sum_ref_sq_reg  <= sum_ref_sq_reg
                                   + {{(SQ_W-PROD_IN_W){xx2_reg[PROD_IN_W-1]}}, xx2_reg};
                sum_meas_sq_reg <= sum_meas_sq_reg
                                   + {{(SQ_W-PROD_IN_W){yy2_reg[PROD_IN_W-1]}}, yy2_reg};
                sum_cross_reg   <= sum_cross_reg
                                   + {{(CROSS_W-PROD_IN_W){xy2_reg[PROD_IN_W-1]}}, xy2_reg};
                sum_diff_sq_reg  <= sum_diff_sq_reg + {{(DSQ_W-DSQ_IN_W){1'b0}}, dsq2_reg};
                sum_abs_diff_reg <= sum_abs_diff_reg + {{(ABS_W-IN_W-1){1'b0}}, ad2_reg};
                if (ad2_reg > peak_reg) begin
                    peak_reg <= ad2_reg;
                end
            end
        end
    end

    // Operand selection for the shared multiplier.
    logic signed [SPROD_W-1:0] op_a, op_b, mul_res;
    logic signed [SPROD_W-1:0] n_ext, sx_ext, sy_ext, sxx_ext, syy_ext, sxy_ext;
    logic signed [SPROD_W-1:0] t1_reg, a_reg, b_reg, c_reg;
    logic                      mul_done;

    assign n_ext   = {{(SPROD_W-CNT_W){1'b0}}, count_reg};
    assign sx_ext  = {{(SPROD_W-SUM_W){sum_ref_reg[SUM_W-1]}}, sum_ref_reg};
    assign sy_ext  = {{(SPROD_W-SUM_W){sum_meas_reg[SUM_W-1]}}, sum_meas_reg};
    assign sxx_ext = {{(SPROD_W-SQ_W){sum_ref_sq_reg[SQ_W-1]}}, sum_ref_sq_reg};
    assign syy_ext = {{(SPROD_W-SQ_W){sum_meas_sq_reg[SQ_W-1]}}, sum_meas_sq_reg};
    assign sxy_ext = {{(SPROD_W-CROSS_W){sum_cross_reg[CROSS_W-1]}}, sum_cross_reg};

    always_comb begin
        unique case (cmd.mul_sel)
            MUL_N_XY: begin op_a = n_ext;  op_b = sxy_ext; end
            MUL_X_Y:  begin op_a = sx_ext; op_b = sy_ext;  end
            MUL_N_XX: begin op_a = n_ext;  op_b = sxx_ext; end
            MUL_X_X:  begin op_a = sx_ext; op_b = sx_ext;  end
            MUL_N_YY: begin op_a = n_ext;  op_b = syy_ext; end
            MUL_Y_Y:  begin op_a = sy_ext; op_b = sy_ext;  end
            MUL_A_A:  begin op_a = a_reg;  op_b = a_reg;   end
            MUL_B_C:  begin op_a = b_reg;  op_b = c_reg;   end
        endcase
    end

    pes_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start_mul),
        .op_a    (op_a),
        .op_b    (op_b),
        .done    (mul_done),
        .res     (mul_res)
    );

    always_ff @(posedge aclk) begin
        unique case (cmd.cap)
            CAP_NONE: ;
            CAP_T1:   t1_reg <= mul_res;
            CAP_A:    a_reg  <= t1_reg - mul_res;
            CAP_B:    b_reg  <= t1_reg - mul_res;
            CAP_C:    c_reg  <= t1_reg - mul_res;
            default:  ;
        endcase
    end

    // Shared divider: MAE, mean square and correlation ratio.
    logic [DIV_W-1:0]  dividend, quotient;
    logic [DVSR_W-1:0] divisor;
    logic [ABS_W:0]    mae_num;
    logic              div_done;
    div_sel_t          div_sel_reg;

    assign mae_num = {1'b0, sum_abs_diff_reg} + {{(ABS_W+1-CNT_W){1'b0}}, count_reg >> 1};

    always_comb begin
        unique case (cmd.div_sel)
            DIV_MAE: begin
                dividend = {{(DIV_W-ABS_W-1){1'b0}}, mae_num};
                divisor  = {{(DVSR_W-CNT_W){1'b0}}, count_reg};
            end
            DIV_RMS: begin
                dividend = {{(DIV_W-DSQ_W-2){1'b0}}, sum_diff_sq_reg, 2'b00};
                divisor  = {{(DVSR_W-CNT_W){1'b0}}, count_reg};
            end
            DIV_CORR: begin
                dividend = {t1_reg[DIV_W-CORR_FRAC-1:0], {CORR_FRAC{1'b0}}};
                divisor  = mul_res[DVSR_W-1:0];
            end
            default: begin
                dividend = '0;
                divisor  = '0;
            end
        endcase
    end

    pes_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start_div),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // Shared square root on the low quotient bits.
    logic [ROOT_W-1:0] root, rms_root_reg, corr_root_reg;
    logic [MAE_W-1:0]  mae_reg;
    logic              sqrt_done;
    sqrt_sel_t         sqrt_sel_reg;

    pes_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start_sqrt),
        .radicand (quotient[RAD_W-1:0]),
        .done     (sqrt_done),
        .root     (root)
    );

    always_ff @(posedge aclk) begin
        if (cmd.start_div) begin
            div_sel_reg <= cmd.div_sel;
        end
        if (cmd.start_sqrt) begin
            sqrt_sel_reg <= cmd.sqrt_sel;
        end
        if (div_done && div_sel_reg == DIV_MAE) begin
            mae_reg <= quotient[MAE_W-1:0];
        end
        if (sqrt_done) begin
            unique case (sqrt_sel_reg)
                SQ_RMS:  rms_root_reg  <= root;
                SQ_CORR: corr_root_reg <= root;
            endcase
        end
    end

    // Rounding of the roots and the result register.
    logic [ROOT_W:0]          rms_rnd, corr_rnd;
    logic [CORR_W-1:0]        corr_mag;
    logic                     n_zero, few, flat;
    logic                     m_valid_reg;

    assign rms_rnd  = ({1'b0, rms_root_reg} + 1'b1) >> 1;
    assign corr_rnd = ({1'b0, corr_root_reg} + 1'b1) >> 1;
    assign corr_mag = corr_rnd[CORR_W-1:0];
    assign n_zero   = (count_reg == '0);
    assign few      = (count_reg < MIN_CNT);
    assign flat     = (b_reg <= 0) || (c_reg <= 0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_rms_error         <= n_zero ? '0 : rms_rnd[RMS_W-1:0];
            m_mean_abs_error    <= n_zero ? '0 : mae_reg;
            m_correlation       <= (few || flat) ? '0 :
                                   (a_reg[SPROD_W-1] ? -$signed(corr_mag) : $signed(corr_mag));
            m_max_abs_error     <= peak_reg[MAX_ERR_W-1:0];
            m_pair_count        <= count_reg;
            m_capacity_overflow <= dropped_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign status.eos_taken = accept & s_end_of_set;
    assign status.pipe_busy = v1_reg | v2_reg;
    assign status.out_busy  = m_valid_reg & ~m_ready;
    assign status.mul_done  = mul_done;
    assign status.div_done  = div_done;
    assign status.sqrt_done = sqrt_done;

endmodule

>>> sv/pes_ctrl.sv
// Controller: sequences accumulation, the end-of-set computation and the result load.
module pes_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  pes_pkg::stat_t  status,
    output pes_pkg::cmd_t   cmd
);
    import pes_pkg::*;

    typedef enum logic [16:0] {
        ST_ACCUM     = 17'b00000000000000001,
        ST_DRAIN     = 17'b00000000000000010,
        ST_MAE_DIV   = 17'b00000000000000100,
        ST_RMS_DIV   = 17'b00000000000001000,
        ST_RMS_SQRT  = 17'b00000000000010000,
        ST_MUL1      = 17'b00000000000100000,
        ST_MUL2      = 17'b00000000001000000,
        ST_MUL3      = 17'b00000000010000000,
        ST_MUL4      = 17'b00000000100000000,
        ST_MUL5      = 17'b00000001000000000,
        ST_MUL6      = 17'b00000010000000000,
        ST_MUL7      = 17'b00000100000000000,
        ST_MUL8      = 17'b00001000000000000,
        ST_CORR_DIV  = 17'b00010000000000000,
        ST_CORR_SQRT = 17'b00100000000000000,
        ST_OUT       = 17'b01000000000000000,
        ST_SPARE     = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd.accept_en  = 1'b0;
        cmd.start_mul  = 1'b0;
        cmd.mul_sel    = MUL_N_XY;
        cmd.cap        = CAP_NONE;
        cmd.start_div  = 1'b0;
        cmd.div_sel    = DIV_MAE;
        cmd.start_sqrt = 1'b0;
        cmd.sqrt_sel   = SQ_RMS;
        cmd.load_out   = 1'b0;
        unique case (state_reg)
            ST_ACCUM: begin
                cmd.accept_en = 1'b1;
                if (status.eos_taken) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    cmd.start_div = 1'b1;
                    cmd.div_sel   = DIV_MAE;
                    state_next    = ST_MAE_DIV;
                end
            end
            ST_MAE_DIV: begin
                if (status.div_done) begin
                    cmd.start_div = 1'b1;
                    cmd.div_sel   = DIV_RMS;
                    state_next    = ST_RMS_DIV;
                end
            end
            ST_RMS_DIV: begin
                if (status.div_done) begin
                    cmd.start_sqrt = 1'b1;
                    cmd.sqrt_sel   = SQ_RMS;
                    state_next     = ST_RMS_SQRT;
                end
            end
            ST_RMS_SQRT: begin
                if (status.sqrt_done) begin
                    cmd.start_mul = 1'b1;
                    cmd.mul_sel   = MUL_N_XY;
                    state_next    = ST_MUL1;
                end
            end
            ST_MUL1: begin
                if (status.mul_done) begin
                    cmd.cap       = CAP_T1;
                    cmd.start_mul = 1'b1;
                    cmd.mul_sel   = MUL_X_Y;
                    state_next    = ST_MUL2;
                end
            end
            ST_MUL2: begin
                if (status.mul_done) begin
                    cmd.cap       = CAP_A;
                    cmd.start_mul = 1'b1;
                    cmd.mul_sel   = MUL_N_XX;
                    state_next    = ST_MUL3;
                end
            end
            ST_MUL3: begin
                if (status.mul_done) begin
                    cmd.cap       = CAP_T1;
                    cmd.start_mul = 1'b1;
                    cmd.mul_sel   = MUL_X_X;
                    state_next    = ST_MUL4;
                end
            end
            ST_MUL4: begin
                if (status.mul_done) begin
                    cmd.cap       = CAP_B;
                    cmd.start_mul = 1'b1;
                    cmd.mul_sel   = MUL_N_YY;
                    state_next    = ST_MUL5;
                end
            end
            ST_MUL5: begin
                if (status.mul_done) begin
                    cmd.cap       = CAP_T1;
                    cmd.start_mul = 1'b1;
                    cmd.mul_sel   = MUL_Y_Y;
                    state_next    = ST_MUL6;
                end
            end
            ST_MUL6: begin
                if (status.mul_done) begin
                    cmd.cap       = CAP_C;
                    cmd.start_mul = 1'b1;
                    cmd.mul_sel   = MUL_A_A;
                    state_next    = ST_MUL7;
                end
            end
            ST_MUL7: begin
                if (status.mul_done) begin
                    cmd.cap       = CAP_T1;
                    cmd.start_mul = 1'b1;
                    cmd.mul_sel   = MUL_B_C;
                    state_next    = ST_MUL8;
                end
            end
            ST_MUL8: begin
                if (status.mul_done) begin
                    cmd.start_div = 1'b1;
                    cmd.div_sel   = DIV_CORR;
                    state_next    = ST_CORR_DIV;
                end
            end
            ST_CORR_DIV: begin
                if (status.div_done) begin
                    cmd.start_sqrt = 1'b1;
                    cmd.sqrt_sel   = SQ_CORR;
                    state_next     = ST_CORR_SQRT;
                end
            end
            ST_CORR_SQRT: begin
                if (status.sqrt_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!status.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default: state_next = ST_ACCUM;
        endcase
    end

endmodule

>>> sv/paired_error_statistics_core.sv
// Top level: pairs in, one transfer of RMSE, MAE, correlation and peak error per set out.
// Pairs are taken one per cycle while the input is open; each accepted pair passes the v1
// and v2 pipeline registers before it reaches the sums. An end-of-set pair closes the input
// through a drain, three restoring divides, eight bit-serial products, two roots and one load.
// The result sits in an output register, so a set may restart while its result waits.
// Synchronous active-low reset clears all sums, the count, the overflow flag and control.
`include "paired_error_statistics_core_assert.svh"

module paired_error_statistics_core #(
    parameter int SAMPLE_BITS = pes_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_PAIRS   = pes_pkg::MAX_PAIRS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [pes_pkg::IN_W-1:0]     s_reference_value,
    input  logic signed [pes_pkg::IN_W-1:0]     s_measured_value,
    input  logic                                s_end_of_set,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pes_pkg::RMS_W-1:0]           m_rms_error,
    output logic [pes_pkg::MAE_W-1:0]           m_mean_abs_error,
    output logic signed [pes_pkg::CORR_W-1:0]   m_correlation,
    output logic [pes_pkg::MAX_ERR_W-1:0]       m_max_abs_error,
    output logic [pes_pkg::CNT_W-1:0]           m_pair_count,
    output logic                                m_capacity_overflow
);
    import pes_pkg::*;

    cmd_t  cmd;
    stat_t status;

    // The controller opens the input only while sums are being built up.
    assign s_ready = cmd.accept_en;

    pes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the sums, the shared multiplier, divider and root unit,
    // and the output register that carries one result transfer per set.
    pes_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_PAIRS   (MAX_PAIRS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .s_valid             (s_valid),
        .s_reference_value   (s_reference_value),
        .s_measured_value    (s_measured_value),
        .s_end_of_set        (s_end_of_set),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_rms_error         (m_rms_error),
        .m_mean_abs_error    (m_mean_abs_error),
        .m_correlation       (m_correlation),
        .m_max_abs_error     (m_max_abs_error),
        .m_pair_count        (m_pair_count),
        .m_capacity_overflow (m_capacity_overflow)
    );

    // After the closing pair of a set the input must stay shut while metrics are computed.
    `PES_ASSERT_NEXT(a_close_after_eos, status.eos_taken, !s_ready, "input open after end of set")
    // A result is loaded only once every pair has reached the sums and the slot is free.
    `PES_ASSERT_NOW(a_load_drained, cmd.load_out, !status.pipe_busy && !status.out_busy, "result loaded early")
    // A new result appears only through a load command.
    `PES_ASSERT_NOW(a_valid_from_load, $rose(m_valid), $past(cmd.load_out), "result valid without load")
    // Arithmetic units are only started while the input is closed.
    `PES_ASSERT_NOW(a_units_idle_input, cmd.start_mul || cmd.start_div || cmd.start_sqrt, !s_ready, "unit started during accumulation")

endmodule
